/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define CHK_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");

// next-cycle implication under reset
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");

`endif

/* hw/rtl/rss_pkg.sv */
// ---------------------------------------------------------------------------
// rss_pkg
// Shared types and codes of the repeating sequence suppressor.
// ---------------------------------------------------------------------------
package rss_pkg;

	// token: message key, module key, level
	localparam int TOK_W = 51;
	typedef logic [TOK_W-1:0] tok_t;

	// result action codes
	localparam logic [1:0] ACT_LOG     = 2'd0;
	localparam logic [1:0] ACT_DROP    = 2'd1;
	localparam logic [1:0] ACT_SUMMARY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLED   = 2'd0;
	localparam logic [1:0] REG_MAX_CYCLE = 2'd1;
	localparam logic [1:0] REG_HIST_SIZE = 2'd2;

endpackage

/* hw/rtl/rss_cell.sv */
// ---------------------------------------------------------------------------
// rss_cell
// One history window cell: holds a token, passes it to its neighbor on
// shift and flags a match against the incoming token.
// ---------------------------------------------------------------------------
module rss_cell import rss_pkg::*; (
	input  logic clk,
	input  logic shift,
	input  tok_t din,
	input  tok_t cur,
	output tok_t dout,
	output logic hit
);

	tok_t tok_q;

	// shift stage
	always_ff @(posedge clk) begin
		if (shift) begin
			tok_q <= din;
		end
	end

	assign dout = tok_q;
	assign hit  = (tok_q == cur);

endmodule

/* hw/rtl/repeating_sequence_suppressor.sv */
// ---------------------------------------------------------------------------
// repeating_sequence_suppressor
// Drops event tokens that continue a repeating cycle, summarizes on a break once it repeated.
// ---------------------------------------------------------------------------
// One word is taken at a time. A token that continues an active cycle passes
// through accept, head normalize, check and result. Any other token reads
// 2*MAX_CYCLE-1 history entries one per cycle from the history memory into
// a row of window cells, then tries one cycle length per cycle. After
// history_size shrinks, the first token wraps the ring head back below the
// ring size in the head normalize step. The result sits in an output
// register, so the next word is taken while it waits.
module repeating_sequence_suppressor import rss_pkg::*; #(
	parameter int HISTORY_DEPTH = 16,
	parameter int MAX_CYCLE     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// message_key[31:0], module_key[47:32], level[50:48], timestamp[82:51]
	input  logic [87:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// action[1:0], summary_repeats[33:2], summary_length[37:34],
	// summary_first_time[69:38], summary_last_time[101:70]
	output logic [103:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [4:0]   cfg_data
);

	localparam int AW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int CW  = (MAX_CYCLE > 1) ? $clog2(MAX_CYCLE) : 1;
	localparam int LW  = $clog2(MAX_CYCLE + 1);
	localparam int W   = 2 * MAX_CYCLE - 1;
	localparam int WCW = $clog2(W + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_NORM, ST_CHECK, ST_LOAD, ST_DETECT, ST_DONE
	} state_t;

	state_t      state_q;
	logic        en_q;
	logic [3:0]  maxc_q;
	logic [4:0]  hsz_q;
	tok_t        tok_q;
	logic [31:0] now_q;
	logic [AW-1:0]  head_q;
	logic [HCW-1:0] cnt_q;
	logic [LW-1:0]  cyc_len_q;
	logic [CW-1:0]  exp_q;
	logic [31:0] rep_q;
	logic [31:0] first_q;
	logic [31:0] last_q;
	tok_t        store_q [MAX_CYCLE];
	tok_t        ring_q [HISTORY_DEPTH];
	tok_t        rd_q;
	logic [AW-1:0]  ptr_q;
	logic [WCW-1:0] ld_cnt_q;
	logic [LW-1:0]  det_len_q;
	logic        try_one_q;
	logic [1:0]  res_act_q;
	logic [31:0] res_rep_q;
	logic [3:0]  res_len_q;
	logic [31:0] res_first_q;
	logic [31:0] res_last_q;
	logic        out_vld_q;
	logic [101:0] out_q;

	logic [HCW-1:0] hs_use;
	logic [LW-1:0]  longest;
	tok_t        win [W];
	logic [W-1:0] hit;
	logic        shift;
	logic        push;
	logic        drop_hit;
	logic        cyc_bad;
	logic        len_ok;
	logic        fin;
	logic [LW-1:0] fin_len;
	logic [CW-1:0] exp_nxt;
	logic        wrap;
	tok_t        src [MAX_CYCLE];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			maxc_q <= 4'd4;
			hsz_q  <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLED:   en_q   <= cfg_data[0];
				REG_MAX_CYCLE: maxc_q <= cfg_data[3:0];
				REG_HIST_SIZE: hsz_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp registers to the built sizes
	always_comb begin
		if (hsz_q == 5'd0) begin
			hs_use = HCW'(1);
		end else if (32'(hsz_q) > HISTORY_DEPTH) begin
			hs_use = HCW'(HISTORY_DEPTH);
		end else begin
			hs_use = HCW'(hsz_q);
		end
		if (maxc_q == 4'd0) begin
			longest = LW'(1);
		end else if (32'(maxc_q) > MAX_CYCLE) begin
			longest = LW'(MAX_CYCLE);
		end else begin
			longest = LW'(maxc_q);
		end
	end

	// window cell row, newest history entry ends in cell 0
	assign shift = (state_q == ST_LOAD) && (ld_cnt_q != '0);
	for (genvar k = 0; k < W; k++) begin : g_cell
		tok_t din;
		if (k == W - 1) begin : g_tail
			assign din = rd_q;
		end else begin : g_mid
			assign din = win[k+1];
		end
		rss_cell u_cell (
			.clk  (clk),
			.shift(shift),
			.din  (din),
			.cur  (tok_q),
			.dout (win[k]),
			.hit  (hit[k])
		);
	end

	// active cycle continuation
	always_comb begin
		drop_hit = (store_q[exp_q] == tok_q);
		cyc_bad  = (cyc_len_q > longest) || (32'(exp_q) >= 32'(cyc_len_q));
		wrap     = (32'(exp_q) + 1 == 32'(cyc_len_q));
		exp_nxt  = wrap ? '0 : exp_q + CW'(1);
	end

	// test of one cycle length against the window
	always_comb begin
		tok_t far;
		logic curm;
		len_ok = 32'(cnt_q) >= 2 * 32'(det_len_q) - 1;
		curm = 1'b0;
		for (int l = 1; l <= MAX_CYCLE; l++) begin
			if (det_len_q == LW'(l)) curm = hit[l-1];
		end
		len_ok = len_ok && curm;
		for (int i = 0; i < MAX_CYCLE - 1; i++) begin
			far = '0;
			for (int l = 2; l <= MAX_CYCLE; l++) begin
				if (det_len_q == LW'(l) && i + l < W) far = win[i+l];
			end
			if (32'(i) + 1 < 32'(det_len_q)) len_ok = len_ok && (win[i] == far);
		end
		for (int i = 0; i < MAX_CYCLE; i++) begin
			for (int j = i + 1; j < MAX_CYCLE; j++) begin
				if (32'(j) < 32'(det_len_q)) len_ok = len_ok && (win[i] != win[j]);
			end
		end
	end

	// detection outcome
	always_comb begin
		if (try_one_q) begin
			if (cnt_q != '0 && hit[0]) begin
				fin     = 1'b1;
				fin_len = LW'(1);
			end else begin
				fin     = (longest < LW'(2));
				fin_len = '0;
			end
		end else begin
			fin     = len_ok || (det_len_q == LW'(2));
			fin_len = len_ok ? det_len_q : '0;
		end
	end

	// cycle store sources: older window entries, newest last
	always_comb begin
		for (int i = 0; i < MAX_CYCLE; i++) begin
			src[i] = tok_q;
			for (int l = 2; l <= MAX_CYCLE; l++) begin
				if (fin_len == LW'(l) && i + 1 < l) src[i] = win[l-2-i];
			end
		end
	end

	assign push = ((state_q == ST_CHECK) && (cyc_len_q != '0) && !cyc_bad && drop_hit)
		|| ((state_q == ST_DETECT) && fin);

	// history memory
	always_ff @(posedge clk) begin
		if (push) begin
			ring_q[head_q] <= tok_q;
		end
		rd_q <= ring_q[ptr_q];
	end

	// sequencer, cycle state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			cnt_q     <= '0;
			cyc_len_q <= '0;
			exp_q     <= '0;
			rep_q     <= '0;
			first_q   <= '0;
			last_q    <= '0;
			ptr_q     <= '0;
			ld_cnt_q  <= '0;
			det_len_q <= '0;
			try_one_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready && state_q != ST_DONE) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						tok_q       <= s_axis_tdata[50:0];
						now_q       <= s_axis_tdata[82:51];
						res_act_q   <= ACT_LOG;
						res_rep_q   <= '0;
						res_len_q   <= '0;
						res_first_q <= '0;
						res_last_q  <= '0;
						state_q     <= en_q ? ST_NORM : ST_DONE;
					end
				end
				ST_NORM: begin
					if (cnt_q > hs_use) begin
						cnt_q <= hs_use;
					end
					if (32'(head_q) >= 32'(hs_use)) begin
						head_q <= head_q - AW'(hs_use);
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					ptr_q     <= (head_q == '0) ? AW'(hs_use - HCW'(1)) : head_q - AW'(1);
					ld_cnt_q  <= '0;
					state_q   <= (cyc_len_q != '0 && !cyc_bad && drop_hit) ? ST_DONE : ST_LOAD;
					if (cyc_len_q != '0) begin
						if (cyc_bad) begin
							cyc_len_q <= '0;
							exp_q     <= '0;
							rep_q     <= '0;
						end else if (drop_hit) begin
							last_q <= now_q;
							exp_q  <= exp_nxt;
							if (wrap && rep_q != 32'hFFFF_FFFF) begin
								rep_q <= rep_q + 32'd1;
							end
							head_q <= (32'(head_q) + 1 == 32'(hs_use)) ? '0 : head_q + AW'(1);
							cnt_q  <= (cnt_q >= hs_use) ? hs_use : cnt_q + HCW'(1);
							res_act_q <= ACT_DROP;
						end else if (rep_q != '0) begin
							res_act_q   <= ACT_SUMMARY;
							res_rep_q   <= rep_q;
							res_len_q   <= 4'(cyc_len_q);
							res_first_q <= first_q;
							res_last_q  <= last_q;
						end else begin
							cyc_len_q <= '0;
							exp_q     <= '0;
							rep_q     <= '0;
						end
					end
				end
				ST_LOAD: begin
					if (32'(ld_cnt_q) < W) begin
						ptr_q    <= (ptr_q == '0) ? AW'(hs_use - HCW'(1)) : ptr_q - AW'(1);
						ld_cnt_q <= ld_cnt_q + WCW'(1);
					end else begin
						det_len_q <= LW'(1);
						try_one_q <= 1'b1;
						state_q   <= ST_DETECT;
					end
				end
				ST_DETECT: begin
					det_len_q <= try_one_q ? longest : det_len_q - LW'(1);
					try_one_q <= 1'b0;
					if (fin) begin
						cyc_len_q <= fin_len;
						exp_q     <= '0;
						rep_q     <= '0;
						if (fin_len != '0) begin
							first_q <= now_q;
							last_q  <= now_q;
							for (int i = 0; i < MAX_CYCLE; i++) begin
								if (32'(i) < 32'(fin_len)) store_q[i] <= src[i];
							end
						end
						head_q  <= (32'(head_q) + 1 == 32'(hs_use)) ? '0 : head_q + AW'(1);
						cnt_q   <= (cnt_q >= hs_use) ? hs_use : cnt_q + HCW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || m_axis_tready) begin
						out_q     <= {res_last_q, res_first_q, res_len_q, res_rep_q, res_act_q};
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/rss_checker.sv */
// ---------------------------------------------------------------------------
// rss_checker
// Port-level checks of the repeating sequence suppressor, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rss_checker import rss_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	// stalled result word holds
	`CHK_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// one word in work at a time
	`CHK_NEXT(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// only the three action codes appear
	`CHK_IMPLIES(a_act_code, clk, arst_n, m_axis_tvalid, m_axis_tdata[1:0] == ACT_LOG || m_axis_tdata[1:0] == ACT_DROP || m_axis_tdata[1:0] == ACT_SUMMARY)

	// summary fields are zero unless a summary
	`CHK_IMPLIES(a_sum_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[1:0] != ACT_SUMMARY, m_axis_tdata[101:2] == '0)

	// a summary always carries at least one repeat
	`CHK_IMPLIES(a_sum_reps, clk, arst_n, m_axis_tvalid && m_axis_tdata[1:0] == ACT_SUMMARY, m_axis_tdata[33:2] != '0)

endmodule

bind repeating_sequence_suppressor rss_checker u_rss_checker (.*);

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the repeating sequence suppressor. A table of
// directed tokens and register writes runs first. Random phases of repeating
// patterns with noise follow. Every result word is checked against a
// behavioral predictor of the cycle detector.
// ---------------------------------------------------------------------------
module tb_top;
	import rss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH  = 16;
	localparam int CYCLE_DEPTH = 8;
	localparam int IDLE_LIMIT  = 5000;

	// one result word, unpacked
	typedef struct {
		logic [1:0]  action;
		logic [31:0] repeats;
		logic [3:0]  length;
		logic [31:0] first_time;
		logic [31:0] last_time;
	} verdict_t;

	// one step of the directed plan: a register write or a token
	typedef struct {
		bit          is_write;
		logic [1:0]  reg_idx;
		logic [4:0]  reg_val;
		tok_t        tok;
		logic [31:0] stamp;
		bit          typed;
		logic [1:0]  typed_action;
	} plan_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [4:0]   cfg_data;

	repeating_sequence_suppressor uut (.*);

	// predictor copy of registers and state
	bit          p_enabled;
	logic [3:0]  p_max_len;
	logic [4:0]  p_hist_size;
	tok_t        p_ring [RING_DEPTH];
	tok_t        p_cycle [CYCLE_DEPTH];
	int unsigned p_head, p_count, p_cyc_len, p_pos;
	logic [31:0] p_repeats, p_first, p_last;

	verdict_t    verdicts_due [$];
	int          fail_count;
	int          burst_left;
	bit          progress;
	bit          long_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned ring_size();
		if (p_hist_size < 1) return 1;
		if (p_hist_size > RING_DEPTH) return RING_DEPTH;
		return p_hist_size;
	endfunction

	function automatic int unsigned longest();
		if (p_max_len < 1) return 1;
		if (p_max_len > CYCLE_DEPTH) return CYCLE_DEPTH;
		return p_max_len;
	endfunction

	// entry counted back from the newest one
	function automatic tok_t ring_back(int unsigned off);
		int unsigned hs;
		hs = ring_size();
		return p_ring[(p_head % hs + 2 * hs - 1 - (off % hs)) % hs];
	endfunction

	function automatic void ring_insert(tok_t t);
		int unsigned hs, pos;
		hs = ring_size();
		pos = p_head % hs;
		p_ring[pos] = t;
		p_head = (pos + 1) % hs;
		if (p_count >= hs) p_count = hs;
		else p_count++;
	endfunction

	// repeating cycle ending in t, length one first, else the longest; 0 if none
	function automatic int unsigned cycle_search(tok_t t);
		int unsigned avail, len;
		bit ok;
		avail = (p_count < ring_size()) ? p_count : ring_size();
		if (avail >= 1 && ring_back(0) == t) begin
			p_cycle[0] = t;
			return 1;
		end
		for (len = longest(); len >= 2; len--) begin
			ok = 1'b1;
			if (avail < 2 * len - 1) continue;
			if (ring_back(len - 1) != t) continue;
			for (int i = 0; ok && i + 1 < len; i++)
				if (ring_back(i) != ring_back(i + len)) ok = 1'b0;
			for (int i = 0; ok && i + 1 < len; i++)
				for (int j = i + 1; ok && j < len; j++)
					if (ring_back(i) == ring_back(j)) ok = 1'b0;
			if (!ok) continue;
			for (int i = 0; i + 1 < len; i++)
				p_cycle[i] = ring_back(len - 2 - i);
			p_cycle[len - 1] = t;
			return len;
		end
		return 0;
	endfunction

	function automatic void restart_cycle(tok_t t, logic [31:0] now);
		int unsigned len;
		len = cycle_search(t);
		p_cyc_len = 0;
		p_pos = 0;
		p_repeats = '0;
		if (len > 0) begin
			p_cyc_len = len;
			p_first = now;
			p_last = now;
		end
	endfunction

	// expected verdict for one token; updates the predictor state
	function automatic verdict_t suppress_verdict(tok_t t, logic [31:0] now);
		verdict_t v;
		v = '{ACT_LOG, '0, '0, '0, '0};
		if (!p_enabled) return v;
		if (p_cyc_len > 0) begin
			if (p_cyc_len > longest() || p_pos >= p_cyc_len) begin
				p_cyc_len = 0;
				p_pos = 0;
				p_repeats = '0;
			end else if (p_cycle[p_pos] == t) begin
				p_last = now;
				p_pos = (p_pos + 1) % p_cyc_len;
				if (p_pos == 0 && p_repeats != 32'hFFFF_FFFF) p_repeats++;
				ring_insert(t);
				v.action = ACT_DROP;
				return v;
			end else if (p_repeats > 0) begin
				v = '{ACT_SUMMARY, p_repeats, 4'(p_cyc_len), p_first, p_last};
				restart_cycle(t, now);
				ring_insert(t);
				return v;
			end else begin
				p_cyc_len = 0;
				p_pos = 0;
				p_repeats = '0;
			end
		end
		restart_cycle(t, now);
		ring_insert(t);
		return v;
	endfunction

	// offer one token word, in bursts with random gaps
	task automatic send_token(tok_t t, logic [31:0] now, bit typed, logic [1:0] act);
		verdict_t v;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, now, t};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		v = suppress_verdict(t, now);
		if (typed) v = '{act, '0, '0, '0, '0};
		verdicts_due.push_back(v);
	endtask

	// stop offering and wait for every due result
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ENABLED:   p_enabled = val[0];
			REG_MAX_CYCLE: p_max_len = val[3:0];
			REG_HIST_SIZE: p_hist_size = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic plan_row_t w_row(logic [1:0] idx, logic [4:0] val);
		return '{1'b1, idx, val, '0, '0, 1'b0, ACT_LOG};
	endfunction

	function automatic plan_row_t t_row(logic [31:0] msg, logic [15:0] modk, logic [2:0] lvl,
			logic [31:0] stamp, bit typed);
		return '{1'b0, REG_ENABLED, '0, {lvl, modk, msg}, stamp, typed, ACT_LOG};
	endfunction

	function automatic tok_t any_token();
		return {3'($urandom), 16'($urandom), $urandom};
	endfunction

	// result receiver: random stall patterns, with a long hold on request
	initial begin
		int mode, hold, tick;
		m_axis_tready = 1'b0;
		mode = 0;
		hold = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold = 400;
				long_hold_req = 1'b0;
			end
			if (++tick % 64 == 0) mode = $urandom_range(0, 3);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 0);
					2: m_axis_tready <= ($urandom_range(0, 4) == 0);
					default: m_axis_tready <= (tick % 3 != 0);
				endcase
			end
		end
	end

	// result checker
	initial begin
		verdict_t want, got;
		forever begin
			@(posedge clk);
			progress = (s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				progress = 1'b1;
				got = '{m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[37:34],
					m_axis_tdata[69:38], m_axis_tdata[101:70]};
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected word, actual action %0d", $time, got.action);
					fail_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.action !== want.action) begin
						$display("%0t: action expected %0d actual %0d", $time, want.action,
							got.action);
						fail_count++;
					end
					if (got.repeats !== want.repeats) begin
						$display("%0t: repeats expected %0d actual %0d", $time, want.repeats,
							got.repeats);
						fail_count++;
					end
					if (got.length !== want.length) begin
						$display("%0t: length expected %0d actual %0d", $time, want.length,
							got.length);
						fail_count++;
					end
					if (got.first_time !== want.first_time) begin
						$display("%0t: first time expected %0h actual %0h", $time,
							want.first_time, got.first_time);
						fail_count++;
					end
					if (got.last_time !== want.last_time) begin
						$display("%0t: last time expected %0h actual %0h", $time,
							want.last_time, got.last_time);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			#1;
			idle = progress ? 0 : idle + 1;
			if (idle >= IDLE_LIMIT) begin
				$display("[repeating_sequence_suppressor] ERROR");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		plan_row_t plan [$];
		tok_t pool [8];
		int order [8];
		int plen, reps, phase_items, sent, k, tmp;
		logic [31:0] stamp;
		tok_t t;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLED;
		cfg_data = '0;
		fail_count = 0;
		burst_left = 0;
		progress = 1'b0;
		long_hold_req = 1'b0;
		p_enabled = 1'b0;
		p_max_len = 4'd4;
		p_hist_size = 5'd16;
		p_head = 0;
		p_count = 0;
		p_cyc_len = 0;
		p_pos = 0;
		p_repeats = '0;
		p_first = '0;
		p_last = '0;
		foreach (p_ring[i]) p_ring[i] = '0;
		foreach (p_cycle[i]) p_cycle[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: disabled after reset, saturated registers, cycles of
		// length one and three with summaries, a break with zero repeats
		plan.push_back(t_row('1, '1, '1, '1, 1'b1));
		plan.push_back(t_row('0, '0, '0, '0, 1'b1));
		plan.push_back(w_row(REG_MAX_CYCLE, 5'd15));
		plan.push_back(w_row(REG_HIST_SIZE, 5'd31));
		plan.push_back(w_row(REG_ENABLED, 5'd1));
		for (int i = 0; i < 4; i++) plan.push_back(t_row('1, '1, '1, i, 1'b0));
		plan.push_back(t_row('1, '1, 3'd6, 32'hFFFF_FFFF, 1'b0));
		for (int i = 0; i < 10; i++)
			plan.push_back(t_row(32'h100 + i % 3, 16'h8000, 3'd1, 100 + i, 1'b0));
		plan.push_back(t_row(32'h100, 16'h8000, 3'd2, 200, 1'b0));
		plan.push_back(t_row(32'h5, 16'h1, 3'd0, 300, 1'b0));
		plan.push_back(t_row(32'h6, 16'h1, 3'd0, 301, 1'b0));
		plan.push_back(t_row(32'h5, 16'h1, 3'd0, 302, 1'b0));
		plan.push_back(t_row(32'h6, 16'h1, 3'd0, 303, 1'b0));
		plan.push_back(t_row(32'h5, 16'h1, 3'd0, 304, 1'b0));
		plan.push_back(t_row(32'h5, 16'h2, 3'd0, 305, 1'b0));
		foreach (plan[i]) begin
			if (plan[i].is_write) write_reg(plan[i].reg_idx, plan[i].reg_val);
			else send_token(plan[i].tok, plan[i].stamp, plan[i].typed, plan[i].typed_action);
		end

		// random phases; the first keeps the full ring so every entry is
		// written before the ring size ever grows
		stamp = 32'd1000;
		for (int phase = 0; phase < 14; phase++) begin
			if (phase == 0) begin
				write_reg(REG_ENABLED, 5'd1);
				write_reg(REG_HIST_SIZE, 5'd16);
			end else begin
				write_reg(REG_ENABLED, 5'($urandom_range(0, 5) != 0));
				case ($urandom_range(0, 3))
					0: write_reg(REG_HIST_SIZE, 5'd0);
					1: write_reg(REG_HIST_SIZE, 5'd31);
					default: write_reg(REG_HIST_SIZE, 5'($urandom_range(0, 31)));
				endcase
			end
			case ($urandom_range(0, 3))
				0: write_reg(REG_MAX_CYCLE, 5'd1);
				1: write_reg(REG_MAX_CYCLE, 5'd15);
				default: write_reg(REG_MAX_CYCLE, 5'($urandom_range(0, 15)));
			endcase
			if (phase == 3) long_hold_req = 1'b1;

			// token pool, some entries differ from another in one key only
			foreach (pool[i]) begin
				pool[i] = any_token();
				if (i > 0 && $urandom_range(0, 3) == 0) begin
					pool[i] = pool[$urandom_range(0, i - 1)];
					case ($urandom_range(0, 2))
						0: pool[i][31:0] = $urandom;
						1: pool[i][47:32] = 16'($urandom);
						default: pool[i][50:48] = pool[i][50:48] + 3'd1;
					endcase
				end
			end
			phase_items = $urandom_range(40, 70);
			sent = 0;
			while (sent < phase_items) begin
				if ($urandom_range(0, 7) == 0) begin
					t = ($urandom_range(0, 1) == 0) ? any_token() : pool[$urandom_range(0, 7)];
					if ($urandom_range(0, 9) == 0) stamp = $urandom;
					send_token(t, stamp, 1'b0, ACT_LOG);
					sent++;
					continue;
				end
				// a cycle of distinct pool tokens, repeated, maybe cut short
				foreach (order[i]) order[i] = i;
				for (int i = 7; i > 0; i--) begin
					k = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[k];
					order[k] = tmp;
				end
				plen = $urandom_range(1, 8);
				reps = $urandom_range(1, 6);
				for (int r = 0; r < reps; r++)
					for (int i = 0; i < plen; i++) begin
						if (r == reps - 1 && i > 0 && $urandom_range(0, 3) == 0) break;
						stamp += $urandom_range(0, 3);
						send_token(pool[order[i]], stamp, 1'b0, ACT_LOG);
						sent++;
					end
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("[repeating_sequence_suppressor] OK");
		end else begin
			$display("[repeating_sequence_suppressor] ERROR");
		end
		$finish;
	end

endmodule
